### sv/sfpb_pkg.sv
// Shared types, constants and helper functions for the bounded small fast PRNG.
package sfpb_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int WARMUP_STEPS = 73;
  localparam int WARM_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

  localparam logic [WORD_W-1:0] RESEED_FILL = 64'h0000_0000_d4e1_2c77;
  localparam logic [WORD_W-1:0] HALF_MASK = {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};

  localparam int ROT_B = 7;
  localparam int ROT_C = 13;
  localparam int ROT_D = 37;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_DRAW64 = 2'd1,
    OP_DRAW32 = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_WARM,
    S_IDLE,
    S_STEP,
    S_TEST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
    logic narrow;
    logic emit;
    logic emit_zero;
  } cmd_t;

  typedef struct packed {
    logic pass;
  } stat_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x, input int k);
    rotl64 = (x << k) | (x >> (WORD_W - k));
  endfunction

  // Set every bit below the top set bit.
  function automatic logic [WORD_W-1:0] smear_right(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] v;
    v = x;
    for (int s = 1; s < WORD_W; s = s * 2) begin
      v = v | (v >> s);
    end
    smear_right = v;
  endfunction

endpackage

### sv/small_fast_prng_bounded.sv
// Top level of the bounded small fast PRNG: controller plus datapath.
// Draw: after the input transfer each generator step takes a step state and then a test
// state; one step for a zero or power-of-two bound, under two on average otherwise.
// A passing test waits while the output slot is full; a new item is taken only when idle.
// Reseed: a load state plus 73 warm-up steps, then a zero result; unused opcode: zero.
// Reset (synchronous, active low) clears the seed and reruns load and warm-up.
module small_fast_prng_bounded import sfpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [WORD_W-1:0] in_bound,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_value
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the load, warm-up, rejection loop and output transfer.
  sfpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the generator words, capture the bound and mask, hold the result.
  sfpb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bound    (in_bound),
    .cmd         (cmd),
    .stat        (stat),
    .out_value   (out_value)
  );

endmodule

### sv/sfpb_ctrl.sv
// Controller state machine: reseed warm-up, draw rejection loop and result transfer.
module sfpb_ctrl import sfpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t            state_r, state_nxt;
  logic [WARM_W-1:0] cnt_r, cnt_nxt;
  logic              reply_r, reply_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;
  logic              accept;
  logic              warm_last;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign warm_last = (cnt_r == WARM_W'(WARMUP_STEPS - 1));
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    reply_nxt = reply_r;
    case (state_r)
      S_LOAD: begin
        cnt_nxt = '0;
        if (WARMUP_STEPS == 0) begin
          state_nxt = reply_r ? S_EMIT : S_IDLE;
        end else begin
          state_nxt = S_WARM;
        end
      end
      S_WARM: begin
        cnt_nxt = cnt_r + 1'b1;
        if (warm_last) begin
          state_nxt = reply_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_RESEED: begin
              state_nxt = S_LOAD;
              reply_nxt = 1'b1;
            end
            OP_DRAW64, OP_DRAW32: state_nxt = S_STEP;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_STEP: state_nxt = S_TEST;
      S_TEST: begin
        if (!stat.pass) begin
          state_nxt = S_STEP;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
          reply_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_LOAD: cmd.load = 1'b1;
      S_WARM: cmd.step = 1'b1;
      S_IDLE: begin
        cmd.capture = accept;
        cmd.narrow  = (op_t'(in_opcode) == OP_DRAW32);
      end
      S_STEP: cmd.step = 1'b1;
      S_TEST: cmd.emit = stat.pass && slot_free;
      S_EMIT: begin
        cmd.emit      = slot_free;
        cmd.emit_zero = 1'b1;
      end
      default: cmd = '0;
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

endmodule

### sv/sfpb_dp.sv
// Datapath: generator state words, seed register, bound mask and result register.
module sfpb_dp import sfpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  input  logic [WORD_W-1:0] in_bound,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [WORD_W-1:0] out_value
);

  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e;
  logic [WORD_W-1:0] n_r, mask_r, value_r;
  logic [WORD_W-1:0] n_in, nm1, mask_nxt;
  logic              pow_r, pow_nxt;
  logic [WORD_W-1:0] res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // One generator step.
  always_comb begin
    e     = a_r - rotl64(b_r, ROT_B);
    a_nxt = b_r ^ rotl64(c_r, ROT_C);
    b_nxt = c_r + rotl64(d_r, ROT_D);
    c_nxt = d_r + e;
    d_nxt = e + a_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= seed_r;
      b_r <= RESEED_FILL;
      c_r <= RESEED_FILL;
      d_r <= RESEED_FILL;
    end else if (cmd.step) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  always_comb begin
    n_in    = cmd.narrow ? (in_bound & HALF_MASK) : in_bound;
    nm1     = n_in - 1'b1;
    pow_nxt = ((n_in & nm1) == '0);
    if (pow_nxt) begin
      mask_nxt = cmd.narrow ? (nm1 & HALF_MASK) : nm1;
    end else begin
      mask_nxt = smear_right(nm1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r    <= n_in;
      mask_r <= mask_nxt;
      pow_r  <= pow_nxt;
    end
  end

  assign res       = d_r & mask_r;
  assign stat.pass = pow_r || (res < n_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value_r <= cmd.emit_zero ? '0 : res;
    end
  end

  assign out_value = value_r;

endmodule

### sv/sfpb_checker.sv
// Port-level assertions for the bounded small fast PRNG, bound to the top level.
module sfpb_checker import sfpb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("stalled result changed");

  a_reset_warm: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during reset warm-up");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind small_fast_prng_bounded sfpb_checker u_sfpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value)
);
